// ===== rtl/core/vertex_rotate_project_assert.svh =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_assert.svh
// Assertion macros shared by the checker of the vertex transform block.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_ASSERT_SVH

// Concurrent assertion on the rising clock edge, switched off while in reset.
`define VRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define VRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Types, widths and helper functions of the vertex transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vrp_pkg;

  localparam int CoordW = 16;
  localparam int ProdW  = 32;
  localparam int SumW   = 34;
  localparam int DivW   = 32;
  localparam int MagW   = 46;
  localparam int NumW   = 47;
  localparam int QuotW  = 18;
  localparam int CmpW   = DivW + QuotW;
  localparam int OutW   = 16;
  localparam int SatW   = 36;
  localparam int RowW   = 48;
  localparam int CfgW   = 48;
  localparam int IdxW   = 3;

  typedef enum logic [IdxW-1:0] {
    RegRowA,
    RegRowB,
    RegRowC,
    RegCenterX,
    RegCenterY,
    RegScale,
    RegViewOff
  } cfg_reg_e;

  typedef struct packed {
    logic [RowW-1:0]          row_a;
    logic [RowW-1:0]          row_b;
    logic [RowW-1:0]          row_c;
    logic [11:0]              center_x;
    logic [11:0]              center_y;
    logic [9:0]               proj_scale;
    logic signed [CoordW-1:0] view_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vert_t;

  typedef struct packed {
    logic signed [SumW-1:0] rx;
    logic signed [SumW-1:0] ry;
    logic signed [SumW-1:0] rz;
  } rot_t;

  typedef struct packed {
    logic [NumW-1:0]        num_x;
    logic [NumW-1:0]        num_y;
    logic [DivW-1:0]        den;
    logic                   neg_x;
    logic                   neg_y;
    logic                   ovf;
    logic                   behind;
    logic signed [OutW-1:0] depth;
  } quo_in_t;

  typedef struct packed {
    logic [QuotW-1:0]       q_x;
    logic [QuotW-1:0]       q_y;
    logic                   neg_x;
    logic                   neg_y;
    logic                   behind;
    logic signed [OutW-1:0] depth;
  } quo_t;

  function automatic logic signed [OutW-1:0] sat16(input logic signed [SatW-1:0] v);
    logic signed [OutW-1:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vrp_rotate.sv =====
// ----------------------------------------------------------------------------
// vrp_rotate
// Two stages: nine coefficient products, then the three row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_rotate import vrp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire vert_t vert_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output rot_t       rot_o
);

  logic [RowW-1:0]          rows [3];
  logic signed [CoordW-1:0] vin  [3];
  logic signed [ProdW-1:0]  prod_d [9];
  logic signed [ProdW-1:0]  prod_q [9];
  logic signed [SumW-1:0]   sum_d  [3];
  rot_t                     rot_q;
  logic                     va_q, vb_q;
  logic                     en_a, en_b;

  assign rows[0] = cfg_i.row_a;
  assign rows[1] = cfg_i.row_b;
  assign rows[2] = cfg_i.row_c;
  assign vin[0]  = vert_i.x;
  assign vin[1]  = vert_i.y;
  assign vin[2]  = vert_i.z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[3*r+k] = $signed(rows[r][16*k +: 16]) * vin[k];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SumW'(prod_q[3*r]) + SumW'(prod_q[3*r+1]) + SumW'(prod_q[3*r+2]);
    end
  end

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) prod_q <= prod_d;
    if (en_b) begin
      rot_q.rx <= sum_d[0];
      rot_q.ry <= sum_d[1];
      rot_q.rz <= sum_d[2];
    end
  end

  assign valid_o = vb_q;
  assign rot_o   = rot_q;

endmodule

`default_nettype wire

// ===== rtl/core/vrp_prep.sv =====
// ----------------------------------------------------------------------------
// vrp_prep
// Two stages: depth, divisor and dividend magnitudes, then the rounding bias.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_prep import vrp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire rot_t rot_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output quo_in_t   prep_o
);

  logic signed [SumW-1:0] off, dsum, ax, ay;
  logic signed [SatW-1:0] dep_full;
  logic [41:0]            px, py;
  logic [MagW-1:0]        mag_x_q, mag_y_q;
  logic [DivW-1:0]        den_q;
  logic                   neg_x_q, neg_y_q, behind_q;
  logic signed [OutW-1:0] depth_q;
  logic [NumW-1:0]        num_x, num_y;
  quo_in_t                prep_q;
  logic                   vc_q, vd_q, en_c, en_d;

  always_comb begin
    off      = SumW'(cfg_i.view_offset) <<< 14;
    dsum     = off + rot_i.rz;
    ax       = rot_i.rx[SumW-1] ? -rot_i.rx : rot_i.rx;
    ay       = rot_i.ry[SumW-1] ? -rot_i.ry : rot_i.ry;
    px       = 42'(cfg_i.proj_scale) * 42'(ax[DivW-1:0]);
    py       = 42'(cfg_i.proj_scale) * 42'(ay[DivW-1:0]);
    // Rounded 128 - rz in Q8.8: floor((2^33 - rz + 2^17) / 2^18).
    dep_full = (36'sd8589934592 - SatW'(rot_i.rz) + 36'sd131072) >>> 18;
  end

  always_comb begin
    num_x = NumW'(mag_x_q) + NumW'(den_q >> 1);
    num_y = NumW'(mag_y_q) + NumW'(den_q >> 1);
  end

  assign en_d    = !vd_q || ready_i;
  assign en_c    = !vc_q || en_d;
  assign ready_o = en_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (en_c) vc_q <= valid_i;
      if (en_d) vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      mag_x_q  <= {px, 4'b0000};
      mag_y_q  <= {py, 4'b0000};
      neg_x_q  <= rot_i.rx[SumW-1];
      neg_y_q  <= rot_i.ry[SumW-1];
      den_q    <= dsum[DivW-1:0];
      behind_q <= dsum[SumW-1] || (dsum == '0);
      depth_q  <= sat16(dep_full);
    end
    if (en_d) begin
      prep_q.num_x  <= num_x;
      prep_q.num_y  <= num_y;
      prep_q.den    <= den_q;
      prep_q.neg_x  <= neg_x_q;
      prep_q.neg_y  <= neg_y_q;
      // Either quotient reaching the range limit saturates the screen value.
      prep_q.ovf    <= 1'b0;
      prep_q.behind <= behind_q;
      prep_q.depth  <= depth_q;
    end
  end

  assign valid_o = vd_q;
  assign prep_o  = prep_q;

endmodule

`default_nettype wire

// ===== rtl/core/vrp_div.sv =====
// ----------------------------------------------------------------------------
// vrp_div
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// the divisor. Quotients beyond the range are flagged before the first stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_div import vrp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire quo_in_t prep_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output quo_t         quo_o
);

  typedef struct packed {
    logic [NumW-1:0]        rem_x;
    logic [NumW-1:0]        rem_y;
    logic [QuotW-1:0]       quo_x;
    logic [QuotW-1:0]       quo_y;
    logic [DivW-1:0]        den;
    logic                   neg_x;
    logic                   neg_y;
    logic                   ovf_x;
    logic                   ovf_y;
    logic                   behind;
    logic signed [OutW-1:0] depth;
  } dstage_t;

  dstage_t         st_in;
  dstage_t         st_q [QuotW];
  logic            v_q  [QuotW];
  logic            en   [QuotW];
  logic [CmpW-1:0] lim;

  always_comb begin
    lim          = {prep_i.den, {QuotW{1'b0}}};
    st_in.rem_x  = prep_i.num_x;
    st_in.rem_y  = prep_i.num_y;
    st_in.quo_x  = '0;
    st_in.quo_y  = '0;
    st_in.den    = prep_i.den;
    st_in.neg_x  = prep_i.neg_x;
    st_in.neg_y  = prep_i.neg_y;
    st_in.ovf_x  = prep_i.ovf || (CmpW'(prep_i.num_x) >= lim);
    st_in.ovf_y  = prep_i.ovf || (CmpW'(prep_i.num_y) >= lim);
    st_in.behind = prep_i.behind;
    st_in.depth  = prep_i.depth;
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    localparam int Bit = QuotW - 1 - s;
    dstage_t         src, nxt;
    logic            src_v, en_nx;
    logic [CmpW-1:0] dsh, rx, ry;

    if (s == 0) begin : g_first
      assign src   = st_in;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[s-1];
      assign src_v = v_q[s-1];
    end

    if (s == QuotW - 1) begin : g_last
      assign en_nx = ready_i;
    end else begin : g_mid
      assign en_nx = en[s+1];
    end

    assign en[s] = !v_q[s] || en_nx;

    always_comb begin
      nxt = src;
      dsh = CmpW'(src.den) << Bit;
      rx  = CmpW'(src.rem_x);
      ry  = CmpW'(src.rem_y);
      if (rx >= dsh) begin
        nxt.rem_x      = NumW'(rx - dsh);
        nxt.quo_x[Bit] = 1'b1;
      end
      if (ry >= dsh) begin
        nxt.rem_y      = NumW'(ry - dsh);
        nxt.quo_y[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) st_q[s] <= nxt;
    end
  end

  assign ready_o      = en[0];
  assign valid_o      = v_q[QuotW-1];
  assign quo_o.q_x    = st_q[QuotW-1].ovf_x ? {QuotW{1'b1}} : st_q[QuotW-1].quo_x;
  assign quo_o.q_y    = st_q[QuotW-1].ovf_y ? {QuotW{1'b1}} : st_q[QuotW-1].quo_y;
  assign quo_o.neg_x  = st_q[QuotW-1].neg_x;
  assign quo_o.neg_y  = st_q[QuotW-1].neg_y;
  assign quo_o.behind = st_q[QuotW-1].behind;
  assign quo_o.depth  = st_q[QuotW-1].depth;

endmodule

`default_nettype wire

// ===== rtl/core/vertex_rotate_project.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Rotates a Q4.12 vertex by a configured Q2.14 matrix and projects it to a
// Q12.4 screen position with a Q8.8 depth value.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                  Transfer
//   s_axis    in         tdata: vert_x, vert_y, vert_z            tvalid & tready
//   m_axis    out        tdata: proj_x, proj_y, depth;            tvalid & tready
//                        tuser: behind_flag
//   cfg       in         cfg_idx_i selects, cfg_data_i value      cfg_we_i
//
// One vertex is taken in every clock cycle unless the input is stalled.
// There are 23 register stages: two rotate stages, two preparation stages,
// 18 divider stages (one quotient bit each) and the output register.
// Each stage holds only while it is full and the stage after it is stalled,
// so bubbles close up and a waiting result blocks new input only once every
// stage is full.
// Reset is asynchronous and active low; it clears the stage valid bits and
// loads the configuration registers with the identity matrix, centre
// (160, 120), scale 64 and view offset 2.0. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_rotate_project import vrp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // Configuration write port.
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  // Vertex input stream.
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire logic [47:0]     s_axis_tdata_i,  // vert_x [15:0], vert_y [31:16], vert_z [47:32]
  // Projected result stream.
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  output logic [47:0]          m_axis_tdata_o,  // proj_x [15:0], proj_y [31:16], depth [47:32]
  output logic                 m_axis_tuser_o   // behind_flag [0]
);

  cfg_t    cfg_q;
  rot_t    rot;
  quo_in_t prep;
  quo_t    quo;
  logic    rot_valid, rot_ready, prep_valid, prep_ready, quo_valid, quo_ready;

  // Configuration registers. Writes to the unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_a       <= 48'h0000_0000_4000;
      cfg_q.row_b       <= 48'h0000_4000_0000;
      cfg_q.row_c       <= 48'h4000_0000_0000;
      cfg_q.center_x    <= 12'd160;
      cfg_q.center_y    <= 12'd120;
      cfg_q.proj_scale  <= 10'd64;
      cfg_q.view_offset <= 16'sd8192;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegRowA:    cfg_q.row_a       <= cfg_data_i;
        RegRowB:    cfg_q.row_b       <= cfg_data_i;
        RegRowC:    cfg_q.row_c       <= cfg_data_i;
        RegCenterX: cfg_q.center_x    <= cfg_data_i[11:0];
        RegCenterY: cfg_q.center_y    <= cfg_data_i[11:0];
        RegScale:   cfg_q.proj_scale  <= cfg_data_i[9:0];
        RegViewOff: cfg_q.view_offset <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // Configuration must be changed only while the pipeline is empty; the block
  // does not enforce this. Every stage reads the live registers directly.
  vrp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .vert_i  (vert_t'(s_axis_tdata_i)),
    .valid_o (rot_valid),
    .ready_i (rot_ready),
    .rot_o   (rot)
  );

  vrp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .rot_i   (rot),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .prep_o  (prep)
  );

  vrp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .prep_i  (prep),
    .valid_o (quo_valid),
    .ready_i (quo_ready),
    .quo_o   (quo)
  );

  // Output stage: centre plus signed quotient, saturated, zero when behind.
  logic signed [19:0]     cx, cy, qx, qy, sx, sy;
  logic signed [OutW-1:0] sx_sat, sy_sat;
  logic [47:0]            tdata_q;
  logic                   tuser_q, tvalid_q;

  always_comb begin
    cx     = $signed({4'b0000, cfg_q.center_x, 4'b0000});
    cy     = $signed({4'b0000, cfg_q.center_y, 4'b0000});
    qx     = $signed({2'b00, quo.q_x});
    qy     = $signed({2'b00, quo.q_y});
    sx     = quo.neg_x ? cx - qx : cx + qx;
    sy     = quo.neg_y ? cy - qy : cy + qy;
    sx_sat = quo.behind ? '0 : sat16(SatW'(sx));
    sy_sat = quo.behind ? '0 : sat16(SatW'(sy));
  end

  assign quo_ready = !tvalid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (quo_ready) begin
      tvalid_q <= quo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quo_ready) begin
      tdata_q <= {quo.depth, sy_sat, sx_sat};
      tuser_q <= quo.behind;
    end
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

endmodule

`default_nettype wire

// ===== rtl/core/vrp_checker.sv =====
// ----------------------------------------------------------------------------
// vrp_checker
// Port-level assertions for the vertex transform block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_rotate_project_assert.svh"

module vrp_assertions (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  logic out_stall, coords_zero;

  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign coords_zero = (m_axis_tdata_o[31:0] == 32'd0);

  // A stalled result keeps its payload.
  `VRP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed")

  // Input back-pressure comes only from a stalled, full output.
  `VRP_ASSERT(a_stall_cause, !s_axis_tready_o |-> out_stall, "input stalled without output stall")

  // A vertex behind the viewer has zero screen coordinates.
  `VRP_ASSERT(a_behind_zero, m_axis_tvalid_o && m_axis_tuser_o |-> coords_zero, "behind, not zero")

  // The depth value can never be negative for any rotated z.
  `VRP_ASSERT(a_depth_pos, m_axis_tvalid_o |-> !m_axis_tdata_o[47], "negative depth")

  // No result is offered while reset is held.
  `VRP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "result valid in reset")

endmodule

bind vertex_rotate_project vrp_assertions u_vrp_assertions (.*);

`default_nettype wire
